FILE: hw/rtl/rbf_kernel_evaluator_defines.svh
// Assertion macros for the RBF kernel evaluator top level.
`ifndef RBF_KERNEL_EVALUATOR_DEFINES_SVH
`define RBF_KERNEL_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked on clk outside reset.
`define RBF_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbf assertion failed");

// Next-cycle implication, checked on clk outside reset.
`define RBF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbf assertion failed");

`endif

FILE: hw/rtl/rbf_pkg.sv
// Types, constants and the exp fraction table of the RBF kernel evaluator.
`default_nettype none

package rbf_pkg;

	localparam int MAX_FEATURES = 256;
	localparam int ADDR_W       = $clog2(MAX_FEATURES);
	localparam int POS_W        = $clog2(MAX_FEATURES + 2);

	localparam int FEAT_W  = 16;
	localparam int GAMMA_W = 24;
	localparam int KERN_W  = 16;
	localparam int ROW_W   = 24;
	localparam int DIST_W  = 48;

	localparam logic [GAMMA_W-1:0] GAMMA_RESET = 24'd65536;
	localparam logic [DIST_W-1:0]  DIST_MAX    = '1;
	localparam logic [30:0]        LOG2E_Q30   = 31'd1549082005;

	localparam logic REQ_REF  = 1'b0;
	localparam logic REQ_DATA = 1'b1;

	// Job queue between the accumulate front end and the exp back end
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);
	localparam logic [QLVL_W-1:0] QFULL = QLVL_W'(QDEPTH);

	typedef struct packed {
		logic               req_type;
		logic signed [15:0] feature_value;
		logic               is_last_feature;
	} rbf_in_t;

	typedef struct packed {
		logic [15:0] kernel_value;
		logic [23:0] row_index;
		logic        length_error;
	} rbf_out_t;

	typedef struct packed {
		logic [DIST_W-1:0] dsum;
		logic [ROW_W-1:0]  row;
		logic              err;
	} rbf_job_t;

	typedef logic [16:0] exp_entry_t;
	typedef exp_entry_t [255:0] exp_table_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] b;
		n = n_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > n)
				b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// T[f] = 2^(-f/256) in Q1.16, built from Q1.31 square-root factors
	function automatic exp_table_t build_exp_table();
		logic [63:0] r [8];
		logic [63:0] p;
		exp_table_t  t;
		r[7] = isqrt64(64'd1 << 61);
		for (int k = 6; k >= 0; k--)
			r[k] = isqrt64(r[k + 1] << 31);
		for (int f = 0; f < 256; f++) begin
			p = 64'd1 << 31;
			for (int k = 0; k < 8; k++) begin
				if (((f >> k) & 1) != 0)
					p = (p * r[k] + (64'd1 << 30)) >> 31;
			end
			t[f] = 17'((p + (64'd1 << 14)) >> 15);
		end
		return t;
	endfunction

	localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

`default_nettype wire

FILE: hw/rtl/rbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rbf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rbf_front.sv
// Front end: takes feature transfers, keeps positions, accumulates squared distance.
`default_nettype none

module rbf_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire rbf_pkg::rbf_in_t           in_item,
	input  wire logic [rbf_pkg::QLVL_W-1:0] q_level,
	output logic                            push,
	output rbf_pkg::rbf_job_t               job
);

	localparam logic [rbf_pkg::POS_W-1:0] MAX_POS = rbf_pkg::POS_W'(rbf_pkg::MAX_FEATURES);
	localparam logic [rbf_pkg::POS_W-1:0] OVF_POS =
		rbf_pkg::POS_W'(rbf_pkg::MAX_FEATURES + 1);

	logic                          accept;
	logic [rbf_pkg::POS_W-1:0]     load_pos_q, load_pos_d;
	logic [rbf_pkg::POS_W-1:0]     ref_len_q, ref_len_d;
	logic [rbf_pkg::POS_W-1:0]     data_pos_q, data_pos_d;
	logic                          ovf_q, ovf_d;
	logic [rbf_pkg::ROW_W-1:0]     row_q, row_d;
	logic                          ram_we;
	logic                          acc_en;
	logic                          data_item;
	logic                          err;
	logic [rbf_pkg::FEAT_W-1:0]    ref_rdata;

	logic                          v_s1, acc_s1, last_s1, err_s1;
	logic signed [15:0]            fv_s1;
	logic [rbf_pkg::ROW_W-1:0]     row_s1;
	logic signed [16:0]            diff;
	logic signed [33:0]            sq_full;

	logic                          v_s2, last_s2, err_s2;
	logic [33:0]                   sq_s2;
	logic [rbf_pkg::ROW_W-1:0]     row_s2;

	logic [rbf_pkg::DIST_W-1:0]    sum_q;
	logic [rbf_pkg::DIST_W:0]      sum_ext;
	logic [rbf_pkg::DIST_W-1:0]    sum_new;
	logic [rbf_pkg::QLVL_W:0]      pending;

	// Count queue slots already promised to vector ends still in the pipe
	always_comb begin
		pending = {1'b0, q_level}
			+ (rbf_pkg::QLVL_W+1)'(v_s1 && last_s1)
			+ (rbf_pkg::QLVL_W+1)'(v_s2 && last_s2);
		in_stall = pending >= (rbf_pkg::QLVL_W+1)'(rbf_pkg::QDEPTH);
	end

	assign accept = in_valid && !in_stall;

	always_comb begin
		ram_we     = 1'b0;
		acc_en     = 1'b0;
		data_item  = 1'b0;
		err        = 1'b0;
		load_pos_d = load_pos_q;
		ref_len_d  = ref_len_q;
		data_pos_d = data_pos_q;
		ovf_d      = ovf_q;
		row_d      = row_q;
		if (accept) begin
			if (in_item.req_type == rbf_pkg::REQ_REF) begin
				if (load_pos_q < MAX_POS) begin
					ram_we     = 1'b1;
					load_pos_d = load_pos_q + 1'b1;
				end else begin
					load_pos_d = OVF_POS;
				end
				if (in_item.is_last_feature) begin
					ref_len_d  = load_pos_d;
					load_pos_d = '0;
				end
			end else begin
				data_item = 1'b1;
				if (data_pos_q >= MAX_POS) begin
					ovf_d = 1'b1;
				end else begin
					acc_en     = data_pos_q < ref_len_q;
					data_pos_d = data_pos_q + 1'b1;
				end
				if (in_item.is_last_feature) begin
					err = ovf_d || (data_pos_d != ref_len_q) || (ref_len_q > MAX_POS);
					data_pos_d = '0;
					ovf_d      = 1'b0;
					row_d      = row_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			ref_len_q  <= '0;
			data_pos_q <= '0;
			ovf_q      <= 1'b0;
			row_q      <= '0;
		end else begin
			load_pos_q <= load_pos_d;
			ref_len_q  <= ref_len_d;
			data_pos_q <= data_pos_d;
			ovf_q      <= ovf_d;
			row_q      <= row_d;
		end
	end

	rbf_ram #(
		.WIDTH(rbf_pkg::FEAT_W),
		.DEPTH(rbf_pkg::MAX_FEATURES)
	) u_ref_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(load_pos_q[rbf_pkg::ADDR_W-1:0]),
		.wdata(in_item.feature_value),
		.raddr(data_pos_q[rbf_pkg::ADDR_W-1:0]),
		.rdata(ref_rdata)
	);

	// Stage 1: reference entry arrives from the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= data_item;
	end

	always_ff @(posedge clk) begin
		acc_s1  <= acc_en;
		last_s1 <= in_item.is_last_feature;
		err_s1  <= err;
		fv_s1   <= in_item.feature_value;
		row_s1  <= row_q;
	end

	always_comb begin
		diff    = {fv_s1[15], fv_s1} - {ref_rdata[15], ref_rdata};
		sq_full = diff * diff;
	end

	// Stage 2: square registered, then saturating accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		last_s2 <= last_s1;
		err_s2  <= err_s1;
		row_s2  <= row_s1;
		sq_s2   <= acc_s1 ? $unsigned(sq_full) : '0;
	end

	always_comb begin
		sum_ext = {1'b0, sum_q} + {15'b0, sq_s2};
		sum_new = sum_ext[rbf_pkg::DIST_W] ? rbf_pkg::DIST_MAX : sum_ext[rbf_pkg::DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (v_s2) begin
			sum_q <= last_s2 ? '0 : sum_new;
		end
	end

	assign push     = v_s2 && last_s2;
	assign job.dsum = sum_new;
	assign job.row  = row_s2;
	assign job.err  = err_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/rbf_queue.sv
// Short job queue between the accumulate front end and the exp back end.
`default_nettype none

module rbf_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire rbf_pkg::rbf_job_t          push_job,
	input  wire logic                       pop,
	output rbf_pkg::rbf_job_t               head,
	output logic [rbf_pkg::QLVL_W-1:0]      level
);

	localparam logic [rbf_pkg::QPTR_W-1:0] LAST_SLOT = rbf_pkg::QPTR_W'(rbf_pkg::QDEPTH - 1);

	rbf_pkg::rbf_job_t            slot_q [rbf_pkg::QDEPTH];
	logic [rbf_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [rbf_pkg::QLVL_W-1:0]   level_q;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				level_q <= level_q + 1'b1;
			else if (pop && !push)
				level_q <= level_q - 1'b1;
		end
	end

	assign head  = slot_q[rd_ptr_q];
	assign level = level_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rbf_exp.sv
// Back end: gamma register, exp(-gamma*d) sequencer and output register.
`default_nettype none

module rbf_exp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [rbf_pkg::GAMMA_W-1:0] cfg_wdata,
	input  wire rbf_pkg::rbf_job_t           head,
	input  wire logic [rbf_pkg::QLVL_W-1:0]  q_level,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output rbf_pkg::rbf_out_t                out_item
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MULH = 6'b000010,
		S_MULL = 6'b000100,
		S_SUM  = 6'b001000,
		S_LOG  = 6'b010000,
		S_EXP  = 6'b100000
	} exp_state_t;

	localparam logic [56:0] X_LIMIT = 57'd12 << 24;

	exp_state_t                     state_q;
	logic [rbf_pkg::GAMMA_W-1:0]    gamma_q;
	logic [rbf_pkg::DIST_W-1:0]     dist_q;
	logic [rbf_pkg::ROW_W-1:0]      row_q;
	logic                           err_q;
	logic [47:0]                    prod_q;
	logic [47:0]                    hi_q;
	logic                           under_q;
	logic [27:0]                    xs_q;
	logic [58:0]                    ly_q;
	logic                           out_valid_q;
	rbf_pkg::rbf_out_t              out_item_q;

	logic [56:0]                    x24;
	logic [59:0]                    yq_sum;
	logic [12:0]                    yq;
	logic [4:0]                     ip;
	logic [16:0]                    tv;
	logic [17:0]                    half;
	logic [17:0]                    vsh;
	logic [15:0]                    kern;
	logic                           out_free;
	logic                           out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gamma_q <= rbf_pkg::GAMMA_RESET;
		else if (cfg_we)
			gamma_q <= cfg_wdata;
	end

	always_comb begin
		x24    = {1'b0, hi_q, 8'b0} + 57'(prod_q >> 16);
		yq_sum = {1'b0, ly_q} + (60'd1 << 45);
		yq     = yq_sum[58:46];
		ip     = yq[12:8];
		tv     = rbf_pkg::EXP_TABLE[yq[7:0]];
		half   = (18'd1 << ip) >> 1;
		vsh    = ({1'b0, tv} + half) >> ip;
		if (under_q)
			kern = '0;
		else if (vsh > 18'd65535)
			kern = 16'hFFFF;
		else
			kern = vsh[15:0];
	end

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == S_IDLE) && (q_level != '0);
	assign out_load = (state_q == S_EXP) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (pop) state_q <= S_MULH;
				S_MULH: state_q <= S_MULL;
				S_MULL: state_q <= S_SUM;
				S_SUM:  state_q <= S_LOG;
				S_LOG:  state_q <= S_EXP;
				S_EXP:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dist_q <= head.dsum;
			row_q  <= head.row;
			err_q  <= head.err;
		end
		// Split gamma*d into high and low halves over one multiplier
		if (state_q == S_MULH)
			prod_q <= gamma_q * dist_q[47:24];
		if (state_q == S_MULL) begin
			hi_q   <= prod_q;
			prod_q <= gamma_q * dist_q[23:0];
		end
		if (state_q == S_SUM) begin
			under_q <= x24 >= X_LIMIT;
			xs_q    <= x24[27:0];
		end
		if (state_q == S_LOG)
			ly_q <= xs_q * rbf_pkg::LOG2E_Q30;
		if (out_load) begin
			out_item_q.kernel_value <= kern;
			out_item_q.row_index    <= row_q;
			out_item_q.length_error <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rbf_kernel_evaluator.sv
// Top level of the Gaussian RBF kernel evaluator.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   in_item  (rbf_in_t)
//   out       output     out_valid / out_stall out_item (rbf_out_t)
//   cfg       input      cfg_we                cfg_wdata (gamma, Q8.16)
//
// One feature per cycle unless stalled; squared distance accumulates after stage 2.
// Each vector end queues a job; the exp sequencer steps MULH, MULL, SUM, LOG, EXP.
// The 4-entry job queue holds vector ends; input stalls only when it would fill.
// Reset clears positions, counters and the accumulator; reference RAM is not cleared.
`default_nettype none

`include "rbf_kernel_evaluator_defines.svh"

module rbf_kernel_evaluator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire rbf_pkg::rbf_in_t            in_item,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output rbf_pkg::rbf_out_t                out_item,
	input  wire logic                        cfg_we,
	input  wire logic [rbf_pkg::GAMMA_W-1:0] cfg_wdata
);

	logic                          q_push;
	logic                          q_pop;
	rbf_pkg::rbf_job_t             q_in;
	rbf_pkg::rbf_job_t             q_head;
	logic [rbf_pkg::QLVL_W-1:0]    q_level;

	rbf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.q_level (q_level),
		.push    (q_push),
		.job     (q_in)
	);

	rbf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_in),
		.pop     (q_pop),
		.head    (q_head),
		.level   (q_level)
	);

	rbf_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.head     (q_head),
		.q_level  (q_level),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	`RBF_ASSERT_IMPL(a_push_has_room, q_push, q_level != rbf_pkg::QFULL)
	`RBF_ASSERT_IMPL(a_pop_not_empty, q_pop, q_level != '0)
	`RBF_ASSERT_NEXT(a_pop_then_busy, q_pop, !q_pop)

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the Gaussian RBF kernel evaluator.
module testbench;
	import rbf_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	rbf_in_t              in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	rbf_out_t             out_item;
	logic                 cfg_we    = 1'b0;
	logic [GAMMA_W-1:0]   cfg_wdata = GAMMA_RESET;

	rbf_kernel_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	rbf_in_t     feature_fifo[$];
	rbf_out_t    kernel_fifo[$];
	int          idle_mode       = 1;
	int          error_count     = 0;
	int          transfers_in    = 0;
	int          results_checked = 0;
	int          gamma_writes    = 0;
	int          queued_total    = 0;
	int unsigned cycle_count     = 0;

	// Reference as the stimulus side sees it, used to build near-miss data
	logic [FEAT_W-1:0] gen_ref[MAX_FEATURES];
	int                gen_load = 0;
	int                gen_len  = 0;

	// Predictor state
	logic [16:0]              exp_frac_lut[256];
	logic [GAMMA_W-1:0]       gamma_now       = GAMMA_RESET;
	logic signed [FEAT_W-1:0] ref_store[MAX_FEATURES];
	int                       ref_length      = 0;
	int                       load_pos        = 0;
	int                       data_pos        = 0;
	logic [DIST_W-1:0]        dist_acc        = '0;
	logic [ROW_W-1:0]         row_count       = '0;
	logic                     beyond_capacity = 1'b0;

	function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	// 2^(-f/256) in Q1.16 from chained Q1.31 square roots of one half
	initial begin : lut_init
		logic [63:0] factor[8];
		logic [63:0] prod;
		factor[7] = floor_sqrt(64'd1 << 61);
		for (int k = 6; k >= 0; k--)
			factor[k] = floor_sqrt(factor[k + 1] << 31);
		for (int f = 0; f < 256; f++) begin
			prod = 64'd1 << 31;
			for (int k = 0; k < 8; k++)
				if (f[k])
					prod = (prod * factor[k] + (64'd1 << 30)) >> 31;
			exp_frac_lut[f] = 17'((prod + (64'd1 << 14)) >> 15);
		end
	end

	function automatic logic [KERN_W-1:0] rbf_of(input logic [DIST_W-1:0] dsq,
			input logic [GAMMA_W-1:0] g);
		logic [63:0] gw;
		logic [63:0] xq;
		logic [63:0] yq;
		logic [63:0] v;
		int unsigned sh;
		gw = 64'(g);
		xq = ((gw * 64'(dsq[47:24])) << 8) + ((gw * 64'(dsq[23:0])) >> 16);
		if (xq >= (64'd12 << 24))
			return '0;
		yq = (xq * 64'(LOG2E_Q30) + (64'd1 << 45)) >> 46;
		sh = int'(yq >> 8);
		v = 64'(exp_frac_lut[yq[7:0]]);
		if (sh != 0)
			v = (v + (64'd1 << (sh - 1))) >> sh;
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic void absorb_feature(input rbf_in_t it);
		longint      diff;
		logic [63:0] sq;
		logic [63:0] sum;
		rbf_out_t    res;
		if (it.req_type == REQ_REF) begin
			if (load_pos < MAX_FEATURES) begin
				ref_store[load_pos] = it.feature_value;
				load_pos++;
			end else begin
				load_pos = MAX_FEATURES + 1;
			end
			if (it.is_last_feature) begin
				ref_length = load_pos;
				load_pos = 0;
			end
			return;
		end
		if (data_pos >= MAX_FEATURES) begin
			beyond_capacity = 1'b1;
		end else begin
			// Features past the reference length only count toward the mismatch
			if (data_pos < ref_length) begin
				diff = longint'($signed(it.feature_value)) - longint'($signed(ref_store[data_pos]));
				sq = 64'(diff * diff);
				sum = 64'(dist_acc) + sq;
				dist_acc = (sum > 64'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
			end
			data_pos++;
		end
		if (it.is_last_feature) begin
			res.kernel_value = rbf_of(dist_acc, gamma_now);
			res.row_index = row_count;
			res.length_error = beyond_capacity || data_pos != ref_length ||
				ref_length > MAX_FEATURES;
			kernel_fifo.push_back(res);
			row_count++;
			dist_acc = '0;
			data_pos = 0;
			beyond_capacity = 1'b0;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (idle_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < ((idle_mode == 2) ? 40 : 70))
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void queue_feature(input logic req, input logic [FEAT_W-1:0] val,
			input logic last);
		rbf_in_t it;
		it.req_type = req;
		it.feature_value = val;
		it.is_last_feature = last;
		feature_fifo.push_back(it);
		queued_total++;
		if (req == REQ_REF) begin
			if (gen_load < MAX_FEATURES)
				gen_ref[gen_load] = val;
			if (gen_load <= MAX_FEATURES)
				gen_load++;
			if (last) begin
				gen_len = gen_load;
				gen_load = 0;
			end
		end
	endfunction

	function automatic logic [FEAT_W-1:0] near_value(input int idx, input int spread_bits);
		logic [FEAT_W-1:0] base;
		logic [FEAT_W-1:0] delta;
		if (spread_bits >= FEAT_W)
			return FEAT_W'($urandom);
		base = (idx < gen_len && idx < MAX_FEATURES) ? gen_ref[idx] : FEAT_W'($urandom);
		delta = FEAT_W'($urandom_range(0, (1 << spread_bits) - 1));
		return $urandom_range(0, 1) ? base + delta : base - delta;
	endfunction

	function automatic int pick_spread();
		if ($urandom_range(0, 9) == 0)
			return FEAT_W;
		return $urandom_range(0, 13);
	endfunction

	function automatic void load_reference(input int len);
		for (int i = 0; i < len; i++)
			queue_feature(REQ_REF, FEAT_W'($urandom), i == len - 1);
	endfunction

	function automatic void send_vector(input int first, input int count, input int spread_bits,
			input bit close);
		for (int i = first; i < first + count; i++)
			queue_feature(REQ_DATA, near_value(i, spread_bits), close && i == first + count - 1);
	endfunction

	function automatic void random_traffic(input int budget);
		int start;
		int r;
		int p;
		start = queued_total;
		while (queued_total - start < budget) begin
			r = $urandom_range(0, 99);
			if (r < 15 || gen_len == 0 || gen_len > 16) begin
				load_reference($urandom_range(1, 8));
			end else if (r < 72) begin
				send_vector(0, gen_len, pick_spread(), 1'b1);
			end else if (r < 84) begin
				send_vector(0, $urandom_range(1, 10), pick_spread(), 1'b1);
			end else if (r < 90) begin
				// reload the reference in the middle of a data vector
				p = $urandom_range(1, gen_len);
				send_vector(0, p, pick_spread(), 1'b0);
				load_reference($urandom_range(1, 8));
				send_vector(p, (gen_len > p) ? gen_len - p : 1, pick_spread(), 1'b1);
			end else if (r < 95) begin
				queue_feature(1'($urandom_range(0, 1)), FEAT_W'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				send_vector(0, gen_len, FEAT_W, 1'b1);
			end
		end
	endfunction

	task automatic write_gamma(input logic [GAMMA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		gamma_now = value;
		gamma_writes++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (feature_fifo.size() != 0 || in_valid || kernel_fifo.size() != 0);
		// let trailing features clear the accumulator
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Input driver
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				absorb_feature(in_item);
				transfers_in++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (feature_fifo.size() > 0) begin
					in_valid <= 1'b1;
					in_item <= feature_fifo.pop_front();
					gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	int stall_left = 0;
	always @(posedge clk) begin : result_check
		rbf_out_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (kernel_fifo.size() == 0) begin
					$error("unexpected result transfer: row_index %0d", out_item.row_index);
					error_count++;
				end else begin
					want = kernel_fifo.pop_front();
					results_checked++;
					if (out_item.kernel_value !== want.kernel_value) begin
						$error("kernel_value: expected %0d, actual %0d",
							want.kernel_value, out_item.kernel_value);
						error_count++;
					end
					if (out_item.row_index !== want.row_index) begin
						$error("row_index: expected %0d, actual %0d",
							want.row_index, out_item.row_index);
						error_count++;
					end
					if (out_item.length_error !== want.length_error) begin
						$error("length_error: expected %0d, actual %0d",
							want.length_error, out_item.length_error);
						error_count++;
					end
				end
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, kernel_fifo.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		logic [GAMMA_W-1:0] g;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, reset gamma of 1.0
		idle_mode = 1;
		queue_feature(REQ_DATA, 16'h0000, 1'b1);    // no reference loaded yet
		queue_feature(REQ_REF, 16'h8000, 1'b0);
		queue_feature(REQ_REF, 16'h7FFF, 1'b1);
		queue_feature(REQ_DATA, 16'h7FFF, 1'b0);    // widest distance
		queue_feature(REQ_DATA, 16'h8000, 1'b1);
		queue_feature(REQ_DATA, 16'h8000, 1'b0);    // exact match
		queue_feature(REQ_DATA, 16'h7FFF, 1'b1);
		queue_feature(REQ_DATA, 16'h0000, 1'b1);    // shorter than reference
		queue_feature(REQ_DATA, 16'h0001, 1'b0);    // longer than reference
		queue_feature(REQ_DATA, 16'h0002, 1'b0);
		queue_feature(REQ_DATA, 16'h0003, 1'b1);
		queue_feature(REQ_DATA, 16'd100, 1'b0);     // reload mid-vector
		queue_feature(REQ_REF, 16'd0, 1'b0);
		queue_feature(REQ_REF, 16'd5, 1'b0);
		queue_feature(REQ_REF, 16'd10, 1'b1);
		queue_feature(REQ_DATA, 16'd200, 1'b0);
		queue_feature(REQ_DATA, 16'd300, 1'b1);
		queue_feature(REQ_DATA, 16'd1, 1'b0);       // small distance
		queue_feature(REQ_DATA, 16'd6, 1'b0);
		queue_feature(REQ_DATA, 16'd9, 1'b1);
		queue_feature(REQ_REF, 16'h1234, 1'b1);
		queue_feature(REQ_DATA, 16'h1274, 1'b1);
		wait_drained();

		idle_mode = 2;
		write_gamma('0);
		random_traffic(30);
		wait_drained();

		idle_mode = 0;
		write_gamma('1);
		random_traffic(30);
		wait_drained();

		// Reference and data both past capacity
		idle_mode = 1;
		write_gamma(GAMMA_RESET);
		load_reference(MAX_FEATURES + 1);
		send_vector(0, 3, 4, 1'b1);
		send_vector(0, MAX_FEATURES + 1, 5, 1'b1);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			idle_mode = ph % 3;
			g = (ph % 2) ? GAMMA_W'($urandom) : GAMMA_W'($urandom_range(0, 1 << 18));
			write_gamma(g);
			random_traffic(70);
			wait_drained();
		end

		$display("Checked %0d kernel results from %0d feature transfers over %0d gamma writes",
			results_checked, transfers_in, gamma_writes);
		$display("Included zero and full-scale gamma, reference reloads and capacity overflow");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
